FILE: sv/heading_tracker_shortest_path_assert.svh
// Assertion macros for the heading tracker checker.
// Used by the checker file only; needs nothing else.
`ifndef HEADING_TRACKER_SHORTEST_PATH_ASSERT_SVH
`define HEADING_TRACKER_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define HTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/hts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the heading tracker.
// Used by every module of the block and by its checker; depends on nothing.
package hts_pkg;

   // Default values of the top-level parameters.
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // Width of the CORDIC x and y datapath: 16-bit inputs, one bit for the
   // negation of the most negative value and two for the CORDIC gain.
   localparam int CORDIC_W = 19;

   // Operation codes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Register indexes.
   localparam logic REG_ROTATION_GAIN    = 1'b0;
   localparam logic REG_SETTLE_THRESHOLD = 1'b1;

   // Register reset values.
   localparam logic [15:0] GAIN_RESET      = 16'd256;
   localparam logic [14:0] THRESHOLD_RESET = 15'd104;

   // Arctangent of 2^-i in units of 2^32 per full turn.
   localparam logic [31:0] ATAN_Q32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   // Input beat.
   typedef struct packed {
      logic              operation;
      logic signed [15:0] new_heading;
      logic signed [15:0] move_x;
      logic signed [15:0] move_z;
      logic        [15:0] time_step;
   } hts_req_type;

   // Result beat.
   typedef struct packed {
      logic signed [15:0] heading;
      logic              rotation_complete;
   } hts_rsp_type;

endpackage

FILE: sv/heading_tracker_shortest_path.sv
`timescale 1ns / 1ps
// Heading tracker: load or slew a binary-angle heading toward atan2(move_x, move_z).
// An update passes the CORDIC unit, which runs one iteration a cycle, then the slew unit
// and the result register; a load goes straight to the result register. One item at a
// time: the next is accepted only after the last has moved to the output register.
// Synchronous active-high reset clears the heading to 0, the gain to 256, the threshold
// to 104 and all handshakes; depends on hts_pkg, hts_cordic and hts_slew.
module heading_tracker_shortest_path import hts_pkg::*; #(
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hts_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hts_rsp_type rsp_payload,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CORDIC = 2'd1;
   localparam logic [1:0] ST_SLEW   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [ANGLE_BITS-1:0] heading_ff, heading_in, res_heading_ff, res_heading_in;
   logic                  res_complete_ff, res_complete_in;
   logic [15:0]           gain_ff, gain_in, time_step_ff, time_step_in;
   logic [14:0]           threshold_ff, threshold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   hts_rsp_type           rsp_payload_ff, rsp_payload_in;

   logic                        req_beat, out_free, cordic_start, cordic_done, slew_start;
   logic                        slew_done, slew_complete;
   logic [ANGLE_BITS-1:0]       cordic_target, slew_heading, load_heading;
   logic [ANGLE_BITS+15:0]      load_ext, res_ext;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_beat     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cordic_start = req_beat && (req_payload.operation == OP_UPDATE);
   assign slew_start   = (state_ff == ST_CORDIC) && cordic_done;

   // Sign extension of a loaded heading, and of the kept heading to the output width.
   assign load_ext     = {{ANGLE_BITS{req_payload.new_heading[15]}}, req_payload.new_heading};
   assign load_heading = load_ext[ANGLE_BITS-1:0];
   assign res_ext      = {{16{res_heading_ff[ANGLE_BITS-1]}}, res_heading_ff};

   hts_cordic #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .move_x(req_payload.move_x),
      .move_z(req_payload.move_z),
      .done  (cordic_done),
      .target(cordic_target)
   );

   hts_slew #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_slew (
      .clock      (clock),
      .reset      (reset),
      .start      (slew_start),
      .target     (cordic_target),
      .heading    (heading_ff),
      .gain       (gain_ff),
      .threshold  (threshold_ff),
      .time_step  (time_step_ff),
      .done       (slew_done),
      .new_heading(slew_heading),
      .complete   (slew_complete)
   );

   // Configuration writes.
   always_comb begin
      gain_in      = gain_ff;
      threshold_in = threshold_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_ROTATION_GAIN:    gain_in      = csr_wdata;
            REG_SETTLE_THRESHOLD: threshold_in = csr_wdata[14:0];
            default:              gain_in      = gain_ff;
         endcase
      end
   end

   // Item sequencer and the result register.
   always_comb begin
      state_in        = state_ff;
      heading_in      = heading_ff;
      res_heading_in  = res_heading_ff;
      res_complete_in = res_complete_ff;
      time_step_in    = time_step_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               time_step_in = req_payload.time_step;
               if (req_payload.operation == OP_LOAD) begin
                  res_heading_in  = load_heading;
                  res_complete_in = 1'b0;
                  state_in        = ST_FINISH;
               end else begin
                  state_in = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               state_in = ST_SLEW;
            end
         end
         ST_SLEW: begin
            if (slew_done) begin
               res_heading_in  = slew_heading;
               res_complete_in = slew_complete;
               state_in        = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               heading_in                       = res_heading_ff;
               rsp_payload_in.heading           = res_ext[15:0];
               rsp_payload_in.rotation_complete = res_complete_ff;
               rsp_valid_in                     = 1'b1;
               state_in                         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         heading_ff   <= '0;
         gain_ff      <= GAIN_RESET;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         gain_ff      <= gain_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_heading_ff  <= res_heading_in;
      res_complete_ff <= res_complete_in;
      time_step_ff    <= time_step_in;
      rsp_payload_ff  <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: sv/hts_cordic.sv
`timescale 1ns / 1ps
// Iterative vectoring CORDIC that forms atan2(move_x, move_z) as a binary angle.
// Depends on hts_pkg for the datapath width and the arctangent table.
module hts_cordic import hts_pkg::*; #(
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [15:0]           move_x,
   input  logic signed [15:0]           move_z,
   output logic                         done,
   output logic        [ANGLE_BITS-1:0] target
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int SHIFT  = 32 - ANGLE_BITS;
   localparam logic [32:0] ROUND = (33'd1 << SHIFT) >> 1;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_W-1:0] x_start, y_start, dx, dy;
   logic        [ANGLE_BITS-1:0] ang_ff, ang_in, step_angle;
   logic        [STEP_W-1:0]     step_ff, step_in;
   logic                         busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic        [32:0]           round_sum, round_shift;
   logic                         y_pos, last_step;

   // Sign-extended start vector; x carries the cosine side.
   assign x_start = {{(CORDIC_W-16){move_z[15]}}, move_z};
   assign y_start = {{(CORDIC_W-16){move_x[15]}}, move_x};

   // Shifted operands and the table angle of this iteration, rounded to the angle width.
   assign dx          = y_ff >>> step_ff;
   assign dy          = x_ff >>> step_ff;
   assign round_sum   = {1'b0, ATAN_Q32[5'(step_ff)]} + ROUND;
   assign round_shift = round_sum >> SHIFT;
   assign step_angle  = round_shift[ANGLE_BITS-1:0];
   assign y_pos       = !y_ff[CORDIC_W-1] && (y_ff != '0);
   assign last_step   = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   // Load on start, then one micro-rotation a cycle.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      ang_in  = ang_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         zero_in = (move_x == 16'sd0) && (move_z == 16'sd0);
         if (move_z[15]) begin
            x_in   = -x_start;
            y_in   = -y_start;
            ang_in = HALF_TURN;
         end else begin
            x_in   = x_start;
            y_in   = y_start;
            ang_in = '0;
         end
      end else if (busy_ff) begin
         if (y_pos) begin
            x_in   = x_ff + dx;
            y_in   = y_ff - dy;
            ang_in = ang_ff + step_angle;
         end else begin
            x_in   = x_ff - dx;
            y_in   = y_ff + dy;
            ang_in = ang_ff - step_angle;
         end
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      ang_ff  <= ang_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // A zero vector points straight ahead.
   assign done   = done_ff;
   assign target = zero_ff ? '0 : ang_ff;

endmodule

FILE: sv/hts_slew.sv
`timescale 1ns / 1ps
// Shortest-path error, settle test and proportional step of the heading.
// Depends on hts_pkg; takes its target from hts_cordic.
module hts_slew import hts_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] target,
   input  logic [ANGLE_BITS-1:0] heading,
   input  logic [15:0]           gain,
   input  logic [14:0]           threshold,
   input  logic [15:0]           time_step,
   output logic                  done,
   output logic [ANGLE_BITS-1:0] new_heading,
   output logic                  complete
);

   localparam int CMP_W = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;

   localparam logic [1:0] SL_IDLE  = 2'd0;
   localparam logic [1:0] SL_MUL1  = 2'd1;
   localparam logic [1:0] SL_MUL2  = 2'd2;
   localparam logic [1:0] SL_APPLY = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [ANGLE_BITS-1:0]    err, mag, mag_ff, mag_in, target_ff, target_in;
   logic                     neg_ff, neg_in, snap_ff, snap_in;
   logic [ANGLE_BITS+15:0]   p1_ff, p1_in;
   logic [ANGLE_BITS+31:0]   p2_ff, p2_in;
   logic [ANGLE_BITS-1:0]    step, result_ff, result_in;
   logic                     done_ff, done_in, complete_ff, complete_in;

   // Wrapped error and its magnitude; a half turn keeps its magnitude.
   assign err  = target - heading;
   assign mag  = err[ANGLE_BITS-1] ? -err : err;
   assign step = p2_ff[ANGLE_BITS+23:24];

   // Error, then two multiplies, then the heading update.
   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      target_in   = target_ff;
      neg_in      = neg_ff;
      snap_in     = snap_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      result_in   = result_ff;
      complete_in = complete_ff;
      done_in     = 1'b0;
      case (state_ff)
         SL_IDLE: begin
            if (start) begin
               mag_in    = mag;
               target_in = target;
               neg_in    = err[ANGLE_BITS-1];
               snap_in   = CMP_W'(mag) < CMP_W'(threshold);
               state_in  = SL_MUL1;
            end
         end
         SL_MUL1: begin
            p1_in    = {16'd0, mag_ff} * {{ANGLE_BITS{1'b0}}, gain};
            state_in = SL_MUL2;
         end
         SL_MUL2: begin
            p2_in    = {16'd0, p1_ff} * {{(ANGLE_BITS+16){1'b0}}, time_step};
            state_in = SL_APPLY;
         end
         SL_APPLY: begin
            if (snap_ff) begin
               result_in = target_ff;
            end else if (neg_ff) begin
               result_in = heading - step;
            end else begin
               result_in = heading + step;
            end
            complete_in = snap_ff;
            done_in     = 1'b1;
            state_in    = SL_IDLE;
         end
         default: begin
            state_in = SL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff      <= mag_in;
      target_ff   <= target_in;
      neg_ff      <= neg_in;
      snap_ff     <= snap_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      result_ff   <= result_in;
      complete_ff <= complete_in;
   end

   assign done        = done_ff;
   assign new_heading = result_ff;
   assign complete    = complete_ff;

endmodule

FILE: sv/hts_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the heading tracker, bound to the top level below.
// Depends on hts_pkg and the assertion macros in heading_tracker_shortest_path_assert.svh.
`include "heading_tracker_shortest_path_assert.svh"

module hts_checker import hts_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input hts_req_type req_payload,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input hts_rsp_type rsp_payload
);

   localparam logic WIDE_ANGLE = (ANGLE_BITS >= 16);

   // A stalled result beat stays and keeps its payload.
   `HTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result beat changed while stalled")

   // Only one item is at work: the block is busy right after taking a beat.
   `HTS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "input taken while an item is at work")

   // A new result only follows a cycle in which the block was busy.
   `HTS_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(!req_ready), "result appeared without work")

   // A load into an empty output comes back through the result and output registers, unflagged and unchanged.
   `HTS_ASSERT_NOW(a_load_result, req_valid && req_ready && (req_payload.operation == OP_LOAD) && !rsp_valid, ##2 (rsp_valid && !rsp_payload.rotation_complete && (!WIDE_ANGLE || (rsp_payload.heading == $past(req_payload.new_heading, 2)))), "load result wrong")

endmodule

bind heading_tracker_shortest_path hts_checker #(
   .ANGLE_BITS(ANGLE_BITS)
) u_hts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_payload(req_payload),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

FILE: dv/heading_tracker_compare.sv
`timescale 1ns / 1ps
// Result checker for the heading tracker: follows the register writes and the accepted
// input beats, predicts each result beat and compares it field by field with the block.
// Depends on hts_pkg for the beat types, operation codes, register indexes and reset values.
module heading_tracker_compare import hts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  hts_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  hts_rsp_type rsp_payload,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          outstanding,
   output int          loads_seen,
   output int          updates_seen,
   output int          snaps_seen
);

   // Arctangent of 2^-i, in units of 2^32 per full turn.
   localparam logic [31:0] ARCTAN_TURNS [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
   };

   // Only the first few mismatch lines are printed; all of them are counted.
   localparam int PRINT_LIMIT = 40;

   // Shadow of the block's state and registers.
   logic [15:0]  heading_now;
   logic [15:0]  gain_now;
   logic [14:0]  threshold_now;
   int           fail_tally;
   hts_rsp_type  expected_q[$];

   // Direction of the vector (sine_side, cosine_side) as a 16-bit binary angle.
   function automatic logic [15:0] bearing_of(input logic signed [15:0] sine_side,
                                              input logic signed [15:0] cosine_side);
      longint      xs;
      longint      ys;
      longint      dx;
      longint      dy;
      logic [31:0] rounded;
      logic [15:0] ang;
      if (sine_side == 0 && cosine_side == 0) begin
         return 16'h0000;
      end
      xs  = cosine_side;
      ys  = sine_side;
      ang = 16'h0000;
      // Fold the left half-plane over by a half turn before vectoring.
      if (xs < 0) begin
         xs  = -xs;
         ys  = -ys;
         ang = 16'h8000;
      end
      for (int i = 0; i < 16; i++) begin
         dx      = ys >>> i;
         dy      = xs >>> i;
         rounded = ARCTAN_TURNS[i] + 32'h0000_8000;
         if (ys > 0) begin
            xs  = xs + dx;
            ys  = ys - dy;
            ang = ang + rounded[31:16];
         end else begin
            xs  = xs - dx;
            ys  = ys + dy;
            ang = ang - rounded[31:16];
         end
      end
      return ang;
   endfunction

   // Applies one input beat to the shadow heading and returns the result it should give.
   function automatic hts_rsp_type slew_heading(input hts_req_type beat);
      hts_rsp_type       outcome;
      logic [15:0]       aim;
      logic signed [15:0] err;
      int                err_wide;
      int unsigned       mag;
      longint unsigned   product;
      logic [15:0]       stride;
      outcome.rotation_complete = 1'b0;
      if (beat.operation == OP_LOAD) begin
         heading_now = beat.new_heading;
      end else begin
         aim      = bearing_of(beat.move_x, beat.move_z);
         err      = aim - heading_now;
         err_wide = err;
         mag      = (err_wide < 0) ? -err_wide : err_wide;
         if (mag < threshold_now) begin
            heading_now               = aim;
            outcome.rotation_complete = 1'b1;
         end else begin
            // Step carries 24 fraction bits; truncate the magnitude, then reapply the sign.
            product = 64'(mag) * 64'(gain_now) * 64'(beat.time_step);
            stride  = product[39:24];
            heading_now = (err_wide < 0) ? heading_now - stride : heading_now + stride;
         end
      end
      outcome.heading = heading_now;
      return outcome;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_tally < PRINT_LIMIT) begin
         $display("%t mismatch: %s", $realtime, what);
      end
      fail_tally++;
   endtask

   // Watch the channels; results are matched before new beats are queued.
   always @(posedge clock) begin
      hts_rsp_type want;
      hts_rsp_type fresh;
      if (reset) begin
         heading_now   = 16'h0000;
         gain_now      = GAIN_RESET;
         threshold_now = THRESHOLD_RESET;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_ROTATION_GAIN:    gain_now      = csr_wdata;
               REG_SETTLE_THRESHOLD: threshold_now = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing outstanding, heading %0d",
                                         rsp_payload.heading));
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.heading !== want.heading) begin
                  report_mismatch($sformatf("heading %0d, expected %0d",
                                            rsp_payload.heading, want.heading));
               end
               if (rsp_payload.rotation_complete !== want.rotation_complete) begin
                  report_mismatch($sformatf("rotation_complete %b, expected %b",
                                            rsp_payload.rotation_complete,
                                            want.rotation_complete));
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh = slew_heading(req_payload);
            expected_q.push_back(fresh);
            if (req_payload.operation == OP_LOAD) begin
               loads_seen <= loads_seen + 1;
            end else begin
               updates_seen <= updates_seen + 1;
            end
            if (fresh.rotation_complete) begin
               snaps_seen <= snaps_seen + 1;
            end
         end
      end
      outstanding <= expected_q.size();
      mismatches  <= fail_tally;
   end

endmodule

FILE: dv/tb_heading_tracker_shortest_path.sv
`timescale 1ns / 1ps
// Top of the heading tracker testbench: clock, reset, stimulus, register writes and verdict.
// Depends on hts_pkg, the block itself and the result checker heading_tracker_compare.
module tb_heading_tracker_shortest_path;
   import hts_pkg::*;

   // Receiver hold-off used to back the block up, and the quiet-cycle limit.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hts_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hts_rsp_type rsp_payload;
   logic        csr_write_en = 1'b0;
   logic        csr_index = REG_ROTATION_GAIN;
   logic [15:0] csr_wdata = 16'h0000;

   int mismatches;
   int outstanding;
   int loads_seen;
   int updates_seen;
   int snaps_seen;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   bit hold_off_request = 1'b0;
   int quiet_cycles = 0;

   heading_tracker_shortest_path dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_write_en, .csr_index, .csr_wdata
   );

   heading_tracker_compare u_compare (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_write_en, .csr_index, .csr_wdata,
      .mismatches, .outstanding, .loads_seen, .updates_seen, .snaps_seen
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Give up if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, outstanding);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stalls, and one long hold-off when asked for.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Field value with a bias towards the extremes and small magnitudes.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'($urandom_range(16)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int idle_run(input int pct);
      int n = 0;
      while (n < 40 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   function automatic hts_req_type load_beat(input logic [15:0] angle);
      hts_req_type beat;
      beat.operation   = OP_LOAD;
      beat.new_heading = angle;
      beat.move_x      = pick_word();
      beat.move_z      = pick_word();
      beat.time_step   = pick_word();
      return beat;
   endfunction

   function automatic hts_req_type update_beat(input logic [15:0] x, input logic [15:0] z,
                                               input logic [15:0] ts);
      hts_req_type beat;
      beat.operation   = OP_UPDATE;
      beat.new_heading = pick_word();
      beat.move_x      = x;
      beat.move_z      = z;
      beat.time_step   = ts;
      return beat;
   endfunction

   // Offer one beat and hold it until taken; valid stays up when the next follows at once.
   task automatic send_beat(input hts_req_type beat, input bit closing);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
      gap = idle_run(req_idle_pct);
      if (closing || gap > 0) begin
         req_valid <= 1'b0;
      end
      if (!closing) begin
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Both registers are written back to back while the block is idle.
   task automatic apply_settings(input logic [15:0] gain, input logic [14:0] threshold);
      csr_write_en <= 1'b1;
      csr_index    <= REG_ROTATION_GAIN;
      csr_wdata    <= gain;
      @(posedge clock);
      csr_index    <= REG_SETTLE_THRESHOLD;
      csr_wdata    <= {1'b0, threshold};
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly runs of updates chasing one direction, with loads and noise mixed in.
   task automatic run_phase(input logic [15:0] gain, input logic [14:0] threshold,
                            input int idle_pct, input int stall_pct, input int count,
                            input int hold_at);
      logic [15:0] dir_x;
      logic [15:0] dir_z;
      int          chase_left;
      int          pick;
      hts_req_type beat;
      wait_drained();
      apply_settings(gain, threshold);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      chase_left    = 0;
      dir_x         = 16'h0000;
      dir_z         = 16'h0000;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) begin
            hold_off_request = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 20) begin
            beat = load_beat(pick_word());
         end else if (pick < 30) begin
            beat = update_beat(pick_word(), pick_word(), pick_word());
         end else begin
            if (chase_left == 0) begin
               dir_x      = pick_word();
               dir_z      = pick_word();
               chase_left = $urandom_range(1, 6);
            end
            chase_left--;
            beat = update_beat(dir_x, dir_z, pick_word());
         end
         send_beat(beat, i == count - 1);
      end
   endtask

   initial begin : stimulus
      hts_req_type opening_q[$];
      logic [15:0] aim;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset register values.
      opening_q.push_back(update_beat(16'h0000, 16'h0000, 16'h0000));
      opening_q.push_back(load_beat(16'h7FFF));
      opening_q.push_back(load_beat(16'h8000));
      opening_q.push_back(update_beat(16'h7FFF, 16'h0000, 16'hFFFF));
      opening_q.push_back(update_beat(16'h8000, 16'h8000, 16'hFFFF));
      opening_q.push_back(update_beat(16'h0000, 16'h8000, 16'h0001));
      opening_q.push_back(update_beat(16'h8000, 16'h7FFF, 16'h0000));
      opening_q.push_back(load_beat(16'h0000));
      opening_q.push_back(update_beat(16'h0000, 16'h0000, 16'hFFFF));
      // Error of exactly a half turn.
      aim = u_compare.bearing_of(16'sd1000, -16'sd3000);
      opening_q.push_back(load_beat(aim + 16'h8000));
      opening_q.push_back(update_beat(16'd1000, -16'sd3000, 16'h8000));
      // Error magnitude on either side of the settle threshold, both signs.
      aim = u_compare.bearing_of(-16'sd20000, 16'sd7000);
      opening_q.push_back(load_beat(aim - THRESHOLD_RESET));
      opening_q.push_back(update_beat(-16'sd20000, 16'sd7000, 16'h4000));
      opening_q.push_back(load_beat(aim - THRESHOLD_RESET + 16'd1));
      opening_q.push_back(update_beat(-16'sd20000, 16'sd7000, 16'h4000));
      opening_q.push_back(load_beat(aim + THRESHOLD_RESET - 16'd1));
      opening_q.push_back(update_beat(-16'sd20000, 16'sd7000, 16'h4000));
      opening_q.push_back(load_beat(aim + THRESHOLD_RESET));
      opening_q.push_back(update_beat(-16'sd20000, 16'sd7000, 16'h4000));
      opening_q.push_back(load_beat(16'hFFFF));
      opening_q.push_back(update_beat(16'h0001, 16'hFFFF, 16'hFFFF));
      foreach (opening_q[i]) begin
         send_beat(opening_q[i], i == opening_q.size() - 1);
      end

      // Random phases across register settings and idling patterns.
      run_phase(16'hFFFF, 15'h7FFF, 0, 0, 60, -1);
      run_phase(16'h0000, 15'h0000, 71, 0, 60, -1);
      run_phase(16'($urandom), 15'($urandom_range(600)), 0, 71, 90, 10);
      run_phase(GAIN_RESET, THRESHOLD_RESET, 14, 14, 90, -1);
      run_phase(16'($urandom_range(128, 4096)), 15'($urandom), 0, 0, 90, -1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d loads and %0d updates, %0d of them settling onto the target,",
               loads_seen, updates_seen, snaps_seen);
      $display("over six register settings from zero to full-scale gain and threshold.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/hts_pkg.sv
sv/hts_cordic.sv
sv/hts_slew.sv
sv/heading_tracker_shortest_path.sv
sv/hts_checker.sv
dv/heading_tracker_compare.sv
dv/tb_heading_tracker_shortest_path.sv
